FILE: src/lfu_pkg.sv
package lfu_pkg;

    localparam int OP_BITS    = 2;
    localparam int ACT_BITS   = 3;
    localparam int CNT_BITS   = 16;
    localparam int SLOT_BITS  = 5;
    localparam int EID_BITS   = 8;
    localparam int CFG_BITS   = 6;
    localparam logic [CFG_BITS-1:0] SLOTS_IN_USE_RESET = 6'd20;
    localparam logic [CNT_BITS-1:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [OP_BITS-1:0] {
        OP_RECOMMEND = 2'd0,
        OP_READOUT   = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_HIT       = 3'd0,
        ACT_FILL      = 3'd1,
        ACT_REPLACE   = 3'd2,
        ACT_READ      = 3'd3,
        ACT_READ_NONE = 3'd4,
        ACT_CLEARED   = 3'd5
    } act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT,
        ST_RD_SCAN,
        ST_RD_EMIT
    } state_t;

endpackage

FILE: src/lfu_cell.sv
module lfu_cell #(
    parameter int ID_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           shift_en,
    input  logic                           write_en,
    input  logic                           age_en,
    input  logic                           clear,
    input  logic                           in_valid,
    input  logic [ID_BITS-1:0]             in_id,
    input  logic [lfu_pkg::CNT_BITS-1:0]   in_count,
    input  logic [lfu_pkg::CNT_BITS-1:0]   in_age,
    output logic                           out_valid,
    output logic [ID_BITS-1:0]             out_id,
    output logic [lfu_pkg::CNT_BITS-1:0]   out_count,
    output logic [lfu_pkg::CNT_BITS-1:0]   out_age
);
    import lfu_pkg::*;

    logic                valid_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] age_reg;

    // rotate: each cell takes its neighbor's contents; write_en loads the same inputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en || write_en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en || write_en)
        begin
            id_reg    <= in_id;
            count_reg <= in_count;
            age_reg   <= in_age;
        end
        else if (age_en && valid_reg && age_reg != CNT_MAX)
        begin
            age_reg <= age_reg + 1'b1;
        end
    end

    assign out_valid = valid_reg;
    assign out_id    = id_reg;
    assign out_count = count_reg;
    assign out_age   = age_reg;
endmodule

FILE: src/lfu_slot_table_oldest_tiebreak.sv
// LFU slot table with oldest-first tie-break. Slots live in a ring of SLOTS
// cells that rotates one position per cycle past a compare head while a pass
// runs. A recommend rotates the ring twice: one pass finds a hit, a victim or
// the next free slot, a decide cycle follows, and a second pass writes the
// target slot and ages every held entry. The result is registered at the end of
// the second pass; a new item is taken only once the table is back in idle.
// The decide cycle waits while an earlier result is still held at the output.
// A readout makes one pass per held entry, one result per pass, with one
// result when the table is empty; a stalled result holds the next pass. After
// each full rotation the ring is back in slot order, so slot k is cell k, but a
// stall at the end of a recommend's second pass keeps the ring rotating.
module lfu_slot_table_oldest_tiebreak #(
    parameter int SLOTS   = 32,
    parameter int ID_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lfu_pkg::CFG_BITS-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lfu_pkg::OP_BITS-1:0]   operation,
    input  logic [7:0]                    candidate_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lfu_pkg::ACT_BITS-1:0]  action,
    output logic [lfu_pkg::SLOT_BITS-1:0] slot,
    output logic [7:0]                    entry_id,
    output logic [7:0]                    evicted_id,
    output logic [lfu_pkg::CNT_BITS-1:0]  hit_count,
    output logic                          last
);
    import lfu_pkg::*;

    localparam int IDX_BITS = $clog2(SLOTS);
    localparam int CNTR_BITS = $clog2(SLOTS + 1);

    logic [CFG_BITS-1:0] cfg_reg;
    state_t state_reg, state_next;
    op_t    op_reg;
    logic [ID_BITS-1:0]   cand_reg;
    logic [CNTR_BITS-1:0] pos_reg, pos_next;
    logic [CNTR_BITS-1:0] fill_reg;
    logic [CNTR_BITS-1:0] held_reg, emitted_reg;

    logic                 hit_reg;
    logic [IDX_BITS-1:0]  hit_idx_reg;
    logic                 best_reg;
    logic [IDX_BITS-1:0]  best_idx_reg;
    logic [CNT_BITS-1:0]  best_cnt_reg, best_age_reg;
    logic [ID_BITS-1:0]   best_id_reg;
    logic                 have_prev_reg;
    logic [ID_BITS-1:0]   prev_id_reg;

    logic                 c_valid [SLOTS];
    logic [ID_BITS-1:0]   c_id    [SLOTS];
    logic [CNT_BITS-1:0]  c_count [SLOTS];
    logic [CNT_BITS-1:0]  c_age   [SLOTS];

    logic                 h_valid;
    logic [ID_BITS-1:0]   h_id;
    logic [CNT_BITS-1:0]  h_count, h_age;
    logic                 shift_en, write_en, age_en, clr;
    logic [IDX_BITS-1:0]  tgt_idx;

    logic                 o_valid_reg;
    logic [ACT_BITS-1:0]  o_act_reg;
    logic [SLOT_BITS-1:0] o_slot_reg;
    logic [7:0]           o_eid_reg, o_evi_reg;
    logic [CNT_BITS-1:0]  o_cnt_reg;
    logic                 o_last_reg;

    logic [CNTR_BITS-1:0] cap;
    logic [IDX_BITS-1:0]  head_idx;

    always_comb
    begin
        if (cfg_reg == '0)
            cap = CNTR_BITS'(1);
        else if (32'(cfg_reg) > SLOTS)
            cap = CNTR_BITS'(SLOTS);
        else
            cap = CNTR_BITS'(cfg_reg);
    end

    // ring: cell i takes from cell i+1, last cell takes the head (cell 0) or a write
    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            logic                iv;
            logic [ID_BITS-1:0]  ii;
            logic [CNT_BITS-1:0] ic, ia;
            logic                we;
            if (g == SLOTS - 1)
            begin : g_tail
                assign iv = h_valid;
                assign ii = h_id;
                assign ic = h_count;
                assign ia = h_age;
                assign we = 1'b0;
            end
            else
            begin : g_mid
                assign iv = c_valid[g+1];
                assign ii = c_id[g+1];
                assign ic = c_count[g+1];
                assign ia = c_age[g+1];
                assign we = 1'b0;
            end
            lfu_cell #(.ID_BITS(ID_BITS)) u_cell (
                .clk(clk), .rst_n(rst_n),
                .shift_en(shift_en), .write_en(we), .age_en(age_en), .clear(clr),
                .in_valid(iv), .in_id(ii), .in_count(ic), .in_age(ia),
                .out_valid(c_valid[g]), .out_id(c_id[g]),
                .out_count(c_count[g]), .out_age(c_age[g])
            );
        end
    endgenerate

    assign head_idx = pos_reg[IDX_BITS-1:0];
    assign tgt_idx  = hit_reg ? hit_idx_reg : best_idx_reg;

    // head modification during the update rotation (pos counts slot at head)
    always_comb
    begin
        h_valid = c_valid[0];
        h_id    = c_id[0];
        h_count = c_count[0];
        h_age   = c_age[0];
        write_en = 1'b0;
        if (state_reg == ST_EMIT && head_idx == tgt_idx)
        begin
            write_en = 1'b1;
            if (hit_reg)
            begin
                if (c_count[0] != CNT_MAX)
                    h_count = c_count[0] + 1'b1;
            end
            else
            begin
                h_valid = 1'b1;
                h_id    = cand_reg;
                h_count = CNT_BITS'(1);
                h_age   = '0;
            end
        end
        if (state_reg == ST_EMIT && h_valid && h_age != CNT_MAX)
            h_age = h_age + 1'b1;
    end

    logic scan_st, emit_st;
    assign scan_st = (state_reg == ST_SCAN) || (state_reg == ST_RD_SCAN);
    assign emit_st = (state_reg == ST_EMIT);
    assign shift_en = scan_st || emit_st;
    assign age_en   = 1'b0;
    assign clr      = (state_reg == ST_DECIDE) && (op_reg == OP_CLEAR);

    logic rd_better;
    assign rd_better = c_valid[0]
        && (!have_prev_reg || c_id[0] > prev_id_reg)
        && (!best_reg || c_id[0] < best_id_reg);

    logic vic_better;
    assign vic_better = c_valid[0]
        && (!best_reg || c_count[0] < best_cnt_reg
            || (c_count[0] == best_cnt_reg && c_age[0] > best_age_reg));

    logic fill_ok;
    assign fill_ok = (fill_reg < cap) && (32'(fill_reg) < SLOTS);

    logic out_free;
    assign out_free = !o_valid_reg || out_ready;

    logic out_set;
    assign out_set = out_free && ((state_reg == ST_DECIDE && op_reg == OP_CLEAR)
        || (emit_st && 32'(pos_reg) == SLOTS - 1) || state_reg == ST_RD_EMIT);

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !o_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                pos_next = '0;
                if (in_valid)
                begin
                    case (op_t'(operation))
                        OP_RECOMMEND: state_next = ST_SCAN;
                        OP_READOUT:   state_next = ST_RD_SCAN;
                        OP_CLEAR:     state_next = ST_DECIDE;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                pos_next = pos_reg + 1'b1;
                if (32'(pos_reg) == SLOTS - 1)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                pos_next = '0;
                if (out_free)
                begin
                    if (op_reg == OP_CLEAR)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                pos_next = pos_reg + 1'b1;
                if (32'(pos_reg) == SLOTS - 1 && out_free)
                    state_next = ST_IDLE;
                else if (32'(pos_reg) == SLOTS - 1)
                    pos_next = pos_reg;
            end
            ST_RD_SCAN:
            begin
                pos_next = pos_reg + 1'b1;
                if (32'(pos_reg) == SLOTS - 1)
                    state_next = ST_RD_EMIT;
            end
            ST_RD_EMIT:
            begin
                pos_next = '0;
                if (out_free)
                begin
                    if (held_reg == '0 || emitted_reg + 1'b1 >= held_reg)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_RD_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            cfg_reg   <= SLOTS_IN_USE_RESET;
            fill_reg  <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (cfg_valid && cfg_ready)
                cfg_reg <= cfg_data;
            if (out_set)
                o_valid_reg <= 1'b1;
            else if (o_valid_reg && out_ready)
                o_valid_reg <= 1'b0;
            if (state_reg == ST_DECIDE && op_reg == OP_CLEAR && out_free)
                fill_reg <= '0;
            else if (emit_st && 32'(pos_reg) == SLOTS - 1 && out_free
                     && !hit_reg && fill_ok)
                fill_reg <= fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            op_reg        <= op_t'(operation);
            cand_reg      <= ID_BITS'(candidate_id);
            hit_reg       <= 1'b0;
            best_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            held_reg      <= '0;
            emitted_reg   <= '0;
        end
        if (state_reg == ST_SCAN)
        begin
            if (!hit_reg && c_valid[0] && c_id[0] == cand_reg)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= head_idx;
            end
            if (vic_better)
            begin
                best_reg     <= 1'b1;
                best_idx_reg <= head_idx;
                best_cnt_reg <= c_count[0];
                best_age_reg <= c_age[0];
                best_id_reg  <= c_id[0];
            end
        end
        if (state_reg == ST_DECIDE && op_reg == OP_RECOMMEND && !hit_reg)
        begin
            if (fill_ok)
                best_idx_reg <= IDX_BITS'(fill_reg);
            else if (!best_reg)
            begin
                best_idx_reg <= '0;
                best_id_reg  <= c_id[0];
            end
        end
        if (state_reg == ST_RD_SCAN)
        begin
            if (!have_prev_reg && c_valid[0])
                held_reg <= held_reg + 1'b1;
            if (rd_better)
            begin
                best_reg     <= 1'b1;
                best_idx_reg <= head_idx;
                best_cnt_reg <= c_count[0];
                best_id_reg  <= c_id[0];
            end
        end
        if (state_reg == ST_RD_EMIT && out_free)
        begin
            have_prev_reg <= 1'b1;
            prev_id_reg   <= best_id_reg;
            best_reg      <= 1'b0;
            emitted_reg   <= emitted_reg + 1'b1;
            o_act_reg     <= best_reg ? ACT_READ : ACT_READ_NONE;
            o_slot_reg    <= best_reg ? SLOT_BITS'(best_idx_reg) : '0;
            o_eid_reg     <= best_reg ? 8'(best_id_reg) : '0;
            o_evi_reg     <= '0;
            o_cnt_reg     <= best_reg ? best_cnt_reg : '0;
            o_last_reg    <= (held_reg == '0) || (emitted_reg + 1'b1 >= held_reg);
        end
        if (state_reg == ST_DECIDE && op_reg == OP_CLEAR && out_free)
        begin
            o_act_reg  <= ACT_CLEARED;
            o_slot_reg <= '0;
            o_eid_reg  <= '0;
            o_evi_reg  <= '0;
            o_cnt_reg  <= '0;
            o_last_reg <= 1'b1;
        end
        if (emit_st && write_en)
        begin
            o_slot_reg <= SLOT_BITS'(tgt_idx);
            o_eid_reg  <= 8'(h_id);
            o_cnt_reg  <= h_count;
            o_last_reg <= 1'b1;
            if (hit_reg)
            begin
                o_act_reg <= ACT_HIT;
                o_evi_reg <= '0;
            end
            else if (fill_ok)
            begin
                o_act_reg <= ACT_FILL;
                o_evi_reg <= '0;
            end
            else
            begin
                o_act_reg <= ACT_REPLACE;
                o_evi_reg <= 8'(c_id[0]);
            end
        end
    end

    assign out_valid  = o_valid_reg;
    assign action     = o_act_reg;
    assign slot       = o_slot_reg;
    assign entry_id   = o_eid_reg;
    assign evicted_id = o_evi_reg;
    assign hit_count  = o_cnt_reg;
    assign last       = o_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= SLOTS)
        else $error("fill level above slot count");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> state_reg == ST_IDLE)
        else $error("config taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(action))
        else $error("result dropped while stalled");
endmodule

FILE: tb/lfu_slot_table_oldest_tiebreak_tb.sv
`timescale 1ns / 1ps

module lfu_slot_table_oldest_tiebreak_tb;
    import lfu_pkg::*;

    localparam int NSLOTS = 32;

    typedef struct packed {
        act_t            act;
        logic [4:0]      slot_idx;
        logic [7:0]      eid;
        logic [7:0]      evid;
        logic [15:0]     cnt;
        logic            lst;
    } table_result_t;

    class lfu_scoreboard;
        bit              held[NSLOTS];
        logic [7:0]      ids[NSLOTS];
        logic [15:0]     counts[NSLOTS];
        logic [15:0]     ages[NSLOTS];
        int              fill;
        logic [5:0]      cap_reg;
        table_result_t   pending[$];
        int              errors;

        function void reset_table();
            for (int i = 0; i < NSLOTS; i++)
            begin
                held[i] = 0;
                ids[i] = '0;
                counts[i] = '0;
                ages[i] = '0;
            end
            fill = 0;
            cap_reg = SLOTS_IN_USE_RESET;
            pending.delete();
            errors = 0;
        endfunction

        function void push(act_t a, int s, logic [7:0] e, logic [7:0] ev,
                           logic [15:0] c, bit l);
            table_result_t r;
            r.act = a;
            r.slot_idx = s[4:0];
            r.eid = e;
            r.evid = ev;
            r.cnt = c;
            r.lst = l;
            pending.insert(pending.size(), r);
        endfunction

        function void note_item(op_t op, logic [7:0] id);
            int cap, hit, best, s, nheld, pick;
            bit done[NSLOTS];
            logic [7:0] ev;
            act_t a;
            cap = (cap_reg == 0) ? 1 : ((cap_reg > NSLOTS) ? NSLOTS : int'(cap_reg));
            case (op)
                OP_RECOMMEND:
                begin
                    hit = -1;
                    ev = '0;
                    for (int i = 0; i < NSLOTS; i++)
                        if (hit < 0 && held[i] && ids[i] == id)
                            hit = i;
                    if (hit >= 0)
                    begin
                        s = hit;
                        if (counts[s] != CNT_MAX)
                            counts[s]++;
                        a = ACT_HIT;
                    end
                    else if (fill < cap)
                    begin
                        s = fill;
                        held[s] = 1;
                        ids[s] = id;
                        counts[s] = 1;
                        ages[s] = 0;
                        fill++;
                        a = ACT_FILL;
                    end
                    else
                    begin
                        best = -1;
                        for (int i = 0; i < NSLOTS; i++)
                            if (held[i] && (best < 0 || counts[i] < counts[best] ||
                                (counts[i] == counts[best] && ages[i] > ages[best])))
                                best = i;
                        if (best < 0)
                            best = 0;
                        s = best;
                        ev = ids[s];
                        held[s] = 1;
                        ids[s] = id;
                        counts[s] = 1;
                        ages[s] = 0;
                        a = ACT_REPLACE;
                    end
                    for (int i = 0; i < NSLOTS; i++)
                        if (held[i] && ages[i] != CNT_MAX)
                            ages[i]++;
                    push(a, s, ids[s], ev, counts[s], 1);
                end
                OP_READOUT:
                begin
                    nheld = 0;
                    for (int i = 0; i < NSLOTS; i++)
                    begin
                        done[i] = 0;
                        if (held[i])
                            nheld++;
                    end
                    if (nheld == 0)
                        push(ACT_READ_NONE, 0, 0, 0, 0, 1);
                    for (int n = 0; n < nheld; n++)
                    begin
                        pick = -1;
                        for (int i = 0; i < NSLOTS; i++)
                            if (held[i] && !done[i] && (pick < 0 || ids[i] < ids[pick]))
                                pick = i;
                        done[pick] = 1;
                        push(ACT_READ, pick, ids[pick], 0, counts[pick], n + 1 == nheld);
                    end
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < NSLOTS; i++)
                        held[i] = 0;
                    fill = 0;
                    push(ACT_CLEARED, 0, 0, 0, 0, 1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(table_result_t got);
            table_result_t w;
            if (pending.size() == 0)
            begin
                $error("unexpected result action=%0d", got.act);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.act !== w.act)
            begin
                $error("action exp %0d got %0d", w.act, got.act);
                errors++;
            end
            if (got.slot_idx !== w.slot_idx)
            begin
                $error("slot exp %0d got %0d", w.slot_idx, got.slot_idx);
                errors++;
            end
            if (got.eid !== w.eid)
            begin
                $error("entry_id exp %0d got %0d", w.eid, got.eid);
                errors++;
            end
            if (got.evid !== w.evid)
            begin
                $error("evicted_id exp %0d got %0d", w.evid, got.evid);
                errors++;
            end
            if (got.cnt !== w.cnt)
            begin
                $error("hit_count exp %0d got %0d", w.cnt, got.cnt);
                errors++;
            end
            if (got.lst !== w.lst)
            begin
                $error("last exp %0d got %0d", w.lst, got.lst);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 0;
    logic                rst_n = 0;
    logic                cfg_valid = 0;
    logic                cfg_ready;
    logic [CFG_BITS-1:0] cfg_data = '0;
    logic                in_valid = 0;
    logic                in_ready;
    logic [OP_BITS-1:0]  operation = '0;
    logic [7:0]          candidate_id = '0;
    logic                out_valid;
    logic                out_ready = 0;
    logic [ACT_BITS-1:0] action;
    logic [SLOT_BITS-1:0] slot;
    logic [7:0]          entry_id;
    logic [7:0]          evicted_id;
    logic [CNT_BITS-1:0] hit_count;
    logic                last;

    lfu_scoreboard lfu_sb;
    int  hold_cycles = 0;
    bit  stall_mode = 0;
    int  gap_left = 0;
    int  burst_left = 0;

    lfu_slot_table_oldest_tiebreak dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .candidate_id(candidate_id),
        .out_valid(out_valid), .out_ready(out_ready),
        .action(action), .slot(slot), .entry_id(entry_id),
        .evicted_id(evicted_id), .hit_count(hit_count), .last(last)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: stall pattern plus an optional long hold-off
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            lfu_sb.check_result({act_t'(action), slot, entry_id, evicted_id, hit_count, last});
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 0;
        end
        else if (stall_mode)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= 1;
    end

    task automatic write_cap(logic [5:0] v);
        cfg_data <= v;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
        lfu_sb.cap_reg = v;
    endtask

    task automatic send_item(op_t op, logic [7:0] id);
        if (stall_mode)
        begin
            if (burst_left == 0)
            begin
                gap_left = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 8);
                repeat (gap_left) @(posedge clk);
            end
            burst_left--;
        end
        operation <= op;
        candidate_id <= id;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lfu_sb.note_item(op, id);
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (lfu_sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
    endtask

    function automatic op_t rand_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return OP_RECOMMEND;
        if (r < 90) return OP_READOUT;
        if (r < 95) return OP_CLEAR;
        return OP_NONE;
    endfunction

    initial
    begin
        logic [5:0] caps[5];
        lfu_sb = new();
        lfu_sb.reset_table();
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed
        send_item(OP_READOUT, 8'h00);
        send_item(OP_RECOMMEND, 8'h00);
        send_item(OP_RECOMMEND, 8'hFF);
        send_item(OP_RECOMMEND, 8'hFF);
        send_item(OP_RECOMMEND, 8'hAA);
        send_item(OP_RECOMMEND, 8'h55);
        send_item(OP_NONE, 8'h12);
        send_item(OP_READOUT, 8'h00);
        drain();
        write_cap(6'd3);
        send_item(OP_RECOMMEND, 8'h01);
        send_item(OP_RECOMMEND, 8'h02);
        send_item(OP_READOUT, 8'h00);
        drain();
        write_cap(6'd0);
        send_item(OP_RECOMMEND, 8'h03);
        send_item(OP_RECOMMEND, 8'h04);
        send_item(OP_READOUT, 8'h00);
        send_item(OP_CLEAR, 8'hFF);
        send_item(OP_READOUT, 8'h00);
        drain();
        write_cap(6'd63);
        for (int i = 0; i < 34; i++)
            send_item(OP_RECOMMEND, 8'(i * 7));
        send_item(OP_READOUT, 8'h00);
        drain();

        // random phases
        caps[0] = 6'd1;
        caps[1] = 6'd4;
        caps[2] = 6'd32;
        caps[3] = 6'd20;
        caps[4] = 6'd8;
        stall_mode = 1;
        for (int p = 0; p < 5; p++)
        begin
            write_cap(caps[p]);
            for (int k = 0; k < 26; k++)
            begin
                if (p == 1 && k == 10)
                    hold_cycles = 600;
                send_item(rand_op(), (p == 3) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 11)));
            end
            drain();
        end
        if (lfu_sb.errors == 0 && lfu_sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: sim.f
src/lfu_pkg.sv
src/lfu_cell.sv
src/lfu_slot_table_oldest_tiebreak.sv
tb/lfu_slot_table_oldest_tiebreak_tb.sv
